// File: design/ffa_pkg.sv
package ffa_pkg;

    localparam int FRAMES_DEFAULT = 64;
    localparam int FRAMES_RESET   = 64;

    localparam int CFG_W       = 7;
    localparam int ACTION_W    = 1;
    localparam int PID_W       = 8;
    localparam int PAGE_W      = 10;
    localparam int FRAME_OUT_W = 6;
    localparam int CNT_OUT_W   = 7;
    localparam int PAGED_W     = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FAULT   = 1'b0,
        ACT_RELEASE = 1'b1
    } action_t;

    typedef enum logic {
        ST_OK       = 1'b0,
        ST_NO_FRAME = 1'b1
    } status_t;

    // control broadcast to every cell of the three chains
    typedef struct packed {
        logic init;     // reload pool after a frames_in_use write
        logic shift;    // load-order chain moves one toward the head
        logic load;     // load-order chain takes a new entry at load_pos
        logic mark;     // drop load-order entries owned by the released pid
        logic sort;     // odd-even compaction step
        logic parity;   // which pairs compare this step
        logic pop;      // free chain moves one toward the head
        logic append;   // free chain takes a frame at its tail
        logic write;    // frame ring records a new owner
        logic rotate;   // frame ring turns one place
    } ffa_ctl_t;

endpackage

// File: design/ffa_ifs.sv
interface ffa_req_if import ffa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [PID_W-1:0]    pid;
    logic [PAGE_W-1:0]   fault_page;

    modport source (output valid, action, pid, fault_page, input ready);
    modport sink   (input valid, action, pid, fault_page, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [FRAME_OUT_W-1:0] frame_index;
    logic                   evicted;
    logic [PID_W-1:0]       victim_owner;
    logic [PAGE_W-1:0]      victim_page;
    logic [CNT_OUT_W-1:0]   freed_count;
    logic [CNT_OUT_W-1:0]   free_count;
    logic [PAGED_W-1:0]     paged_in_count;
    logic                   status;

    modport source (output valid, frame_index, evicted, victim_owner, victim_page, freed_count,
                    free_count, paged_in_count, status, input ready);
    modport sink   (input valid, frame_index, evicted, victim_owner, victim_page, freed_count,
                    free_count, paged_in_count, status, output ready);
endinterface

// File: design/ffa_order_cell.sv
// One slot of the load-order queue: frame, its owner and page.
module ffa_order_cell import ffa_pkg::*; #(
    parameter int INDEX   = 0,
    parameter int FRAME_W = 6,
    parameter int CNT_W   = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ffa_ctl_t           ctl,
    input  logic [CNT_W-1:0]   load_pos,
    input  logic [FRAME_W-1:0] load_frame,
    input  logic [PID_W-1:0]   load_owner,
    input  logic [PAGE_W-1:0]  load_page,
    input  logic [PID_W-1:0]   rel_pid,
    input  logic               left_valid,
    input  logic               right_valid,
    input  logic [FRAME_W-1:0] right_frame,
    input  logic [PID_W-1:0]   right_owner,
    input  logic [PAGE_W-1:0]  right_page,
    output logic               valid,
    output logic [FRAME_W-1:0] frame,
    output logic [PID_W-1:0]   owner,
    output logic [PAGE_W-1:0]  page
);
    localparam logic [CNT_W-1:0] POS     = CNT_W'(INDEX);
    localparam logic             IDX_LSB = 1'(INDEX % 2);

    logic               valid_reg, valid_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [PID_W-1:0]   owner_reg, owner_next;
    logic [PAGE_W-1:0]  page_reg, page_next;

    always_comb
    begin
        valid_next = valid_reg;
        frame_next = frame_reg;
        owner_next = owner_reg;
        page_next  = page_reg;
        if (ctl.init)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            if (ctl.shift)
            begin
                valid_next = right_valid;
                frame_next = right_frame;
                owner_next = right_owner;
                page_next  = right_page;
            end
            else if (ctl.mark)
            begin
                if (valid_reg && owner_reg == rel_pid)
                    valid_next = 1'b0;
            end
            else if (ctl.sort)
            begin
                if (IDX_LSB == ctl.parity)
                begin
                    // left of a pair: pull the neighbor into a hole
                    if (!valid_reg && right_valid)
                    begin
                        valid_next = 1'b1;
                        frame_next = right_frame;
                        owner_next = right_owner;
                        page_next  = right_page;
                    end
                end
                else if (!left_valid && valid_reg)
                begin
                    valid_next = 1'b0;
                end
            end
            if (ctl.load && load_pos == POS)
            begin
                valid_next = 1'b1;
                frame_next = load_frame;
                owner_next = load_owner;
                page_next  = load_page;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        owner_reg <= owner_next;
        page_reg  <= page_next;
    end

    assign valid = valid_reg;
    assign frame = frame_reg;
    assign owner = owner_reg;
    assign page  = page_reg;

endmodule

// File: design/ffa_free_cell.sv
// One slot of the free list; slot count lives in the top level.
module ffa_free_cell import ffa_pkg::*; #(
    parameter int INDEX   = 0,
    parameter int FRAME_W = 6,
    parameter int CNT_W   = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ffa_ctl_t           ctl,
    input  logic [CNT_W-1:0]   append_pos,
    input  logic [FRAME_W-1:0] append_frame,
    input  logic [FRAME_W-1:0] right_frame,
    output logic [FRAME_W-1:0] frame
);
    localparam logic [CNT_W-1:0]   POS  = CNT_W'(INDEX);
    localparam logic [FRAME_W-1:0] HOME = FRAME_W'(INDEX);

    logic [FRAME_W-1:0] frame_reg, frame_next;

    always_comb
    begin
        frame_next = frame_reg;
        if (ctl.init)
            frame_next = HOME;
        else if (ctl.pop)
            frame_next = right_frame;
        else if (ctl.append && append_pos == POS)
            frame_next = append_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_reg <= HOME;
        else
            frame_reg <= frame_next;
    end

    assign frame = frame_reg;

endmodule

// File: design/ffa_frame_cell.sv
// One place of the frame ring: used bit and owner of one frame.
module ffa_frame_cell import ffa_pkg::*; #(
    parameter int INDEX   = 0,
    parameter int FRAME_W = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ffa_ctl_t           ctl,
    input  logic [FRAME_W-1:0] wr_frame,
    input  logic [PID_W-1:0]   wr_owner,
    input  logic               right_used,
    input  logic [PID_W-1:0]   right_owner,
    output logic               used,
    output logic [PID_W-1:0]   owner
);
    localparam logic [FRAME_W-1:0] HOME = FRAME_W'(INDEX);

    logic             used_reg, used_next;
    logic [PID_W-1:0] owner_reg, owner_next;

    always_comb
    begin
        used_next  = used_reg;
        owner_next = owner_reg;
        if (ctl.init)
        begin
            used_next = 1'b0;
        end
        else if (ctl.rotate)
        begin
            used_next  = right_used;
            owner_next = right_owner;
        end
        else if (ctl.write && wr_frame == HOME)
        begin
            used_next  = 1'b1;
            owner_next = wr_owner;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= 1'b0;
        else
            used_reg <= used_next;
    end

    always_ff @(posedge clk)
    begin
        owner_reg <= owner_next;
    end

    assign used  = used_reg;
    assign owner = owner_reg;

endmodule

// File: design/fifo_frame_allocator.sv
// Channel  | Dir | Handshake      | Payload
// ---------+-----+----------------+---------------------------------------------
// cfg      | in  | cfg_we         | cfg_wdata = frames_in_use (saturated)
// req      | in  | valid/ready    | action, pid, fault_page
// rsp      | out | valid/ready    | frame_index, evicted, victim_owner/page,
//          |     |                | freed_count, free_count, paged_in_count, status
//
// Fault: result registered on the accepting edge.
// Release: the frame ring turns once past its head cell, one frame
//   per cycle, while the load-order chain compacts with odd-even steps
//   in the same cycles.
// A new transfer is taken only in idle and when the result register is free.
// Reset (async, active low) and a cfg write both reload the pool: no
//   clearing pass, every slot resets at once.
module fifo_frame_allocator import ffa_pkg::*; #(
    parameter int MAX_FRAMES = FRAMES_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    ffa_req_if.sink          req,
    ffa_rsp_if.source        rsp
);
    localparam int FW      = $clog2(MAX_FRAMES);
    localparam int CW      = $clog2(MAX_FRAMES + 1);
    localparam int RESET_N = (FRAMES_RESET > MAX_FRAMES) ? MAX_FRAMES : FRAMES_RESET;
    localparam logic [FW-1:0] LAST_SCAN = FW'(MAX_FRAMES - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      fcount_reg, fcount_next;    // free list fill
    logic [CW-1:0]      lcount_reg, lcount_next;    // load-order fill
    logic [PAGED_W-1:0] faults_reg, faults_next;
    logic [CW-1:0]      freed_reg, freed_next;
    logic [PID_W-1:0]   pid_reg, pid_next;
    logic [FW-1:0]      scan_reg, scan_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic [FRAME_OUT_W-1:0] out_frame_reg, out_frame_next;
    logic                   out_evicted_reg, out_evicted_next;
    logic [PID_W-1:0]       out_vpid_reg, out_vpid_next;
    logic [PAGE_W-1:0]      out_vpage_reg, out_vpage_next;
    logic [CNT_OUT_W-1:0]   out_freed_reg, out_freed_next;
    logic [CNT_OUT_W-1:0]   out_free_reg, out_free_next;
    logic [PAGED_W-1:0]     out_paged_reg, out_paged_next;
    status_t                out_status_reg, out_status_next;

    // chain taps
    logic             o_valid [MAX_FRAMES];
    logic [FW-1:0]    o_frame [MAX_FRAMES];
    logic [PID_W-1:0] o_owner [MAX_FRAMES];
    logic [PAGE_W-1:0] o_page [MAX_FRAMES];
    logic [FW-1:0]    f_frame [MAX_FRAMES];
    logic             r_used  [MAX_FRAMES];
    logic [PID_W-1:0] r_owner [MAX_FRAMES];

    ffa_ctl_t      ctl;
    logic          accept, is_fault, is_rel, have_free, have_lo, hit, out_free_slot;
    logic [CW-1:0] load_pos, cfg_sat;
    logic [FW-1:0] load_frame;

    assign out_free_slot = !out_valid_reg || rsp.ready;
    assign req.ready     = (state_reg == S_IDLE) && out_free_slot;
    assign accept        = req.valid && req.ready;
    assign is_fault      = accept && (req.action == ACT_FAULT);
    assign is_rel        = accept && (req.action == ACT_RELEASE);
    assign have_free     = (fcount_reg != '0);
    assign have_lo       = (lcount_reg != '0);
    // frame now at the ring head is scan_reg
    assign hit           = (state_reg == S_SCAN) && r_used[0] && (r_owner[0] == pid_reg);

    assign cfg_sat    = (32'(cfg_wdata) > 32'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(cfg_wdata);
    assign load_pos   = have_free ? lcount_reg : lcount_reg - 1'b1;
    assign load_frame = have_free ? f_frame[0] : o_frame[0];

    always_comb
    begin
        ctl        = '0;
        ctl.init   = cfg_we;
        ctl.pop    = is_fault && have_free;
        ctl.shift  = is_fault && !have_free && have_lo;   // evict the oldest load
        ctl.load   = ctl.pop || ctl.shift;
        ctl.write  = ctl.load;
        ctl.mark   = is_rel;
        ctl.sort   = (state_reg == S_SCAN);
        ctl.parity = scan_reg[0];
        ctl.rotate = (state_reg == S_SCAN);
        ctl.append = hit;
    end

    for (genvar k = 0; k < MAX_FRAMES; k++)
    begin : g_cell
        logic             lv, rv, ru;
        logic [FW-1:0]    rf, rff;
        logic [PID_W-1:0] ro, rro;
        logic [PAGE_W-1:0] rp;

        if (k == 0)
        begin : g_head
            assign lv = 1'b1;
        end
        else
        begin : g_mid
            assign lv = o_valid[k-1];
        end

        if (k == MAX_FRAMES - 1)
        begin : g_tail
            assign rv  = 1'b0;
            assign rf  = '0;
            assign ro  = '0;
            assign rp  = '0;
            assign rff = '0;
            // ring closes: the head frame returns with its used bit cleared on a hit
            assign ru  = r_used[0] && !hit;
            assign rro = r_owner[0];
        end
        else
        begin : g_body
            assign rv  = o_valid[k+1];
            assign rf  = o_frame[k+1];
            assign ro  = o_owner[k+1];
            assign rp  = o_page[k+1];
            assign rff = f_frame[k+1];
            assign ru  = r_used[k+1];
            assign rro = r_owner[k+1];
        end

        ffa_order_cell #(.INDEX(k), .FRAME_W(FW), .CNT_W(CW)) u_order (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .load_pos    (load_pos),
            .load_frame  (load_frame),
            .load_owner  (req.pid),
            .load_page   (req.fault_page),
            .rel_pid     (req.pid),
            .left_valid  (lv),
            .right_valid (rv),
            .right_frame (rf),
            .right_owner (ro),
            .right_page  (rp),
            .valid       (o_valid[k]),
            .frame       (o_frame[k]),
            .owner       (o_owner[k]),
            .page        (o_page[k])
        );

        ffa_free_cell #(.INDEX(k), .FRAME_W(FW), .CNT_W(CW)) u_free (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .append_pos   (fcount_reg),
            .append_frame (scan_reg),
            .right_frame  (rff),
            .frame        (f_frame[k])
        );

        ffa_frame_cell #(.INDEX(k), .FRAME_W(FW)) u_frame (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .wr_frame    (load_frame),
            .wr_owner    (req.pid),
            .right_used  (ru),
            .right_owner (rro),
            .used        (r_used[k]),
            .owner       (r_owner[k])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        fcount_next = fcount_reg;
        lcount_next = lcount_reg;
        faults_next = faults_reg;
        freed_next  = freed_reg;
        pid_next    = pid_reg;
        scan_next   = scan_reg;

        out_valid_next   = out_valid_reg && !rsp.ready;
        out_frame_next   = out_frame_reg;
        out_evicted_next = out_evicted_reg;
        out_vpid_next    = out_vpid_reg;
        out_vpage_next   = out_vpage_reg;
        out_freed_next   = out_freed_reg;
        out_free_next    = out_free_reg;
        out_paged_next   = out_paged_reg;
        out_status_next  = out_status_reg;

        if (cfg_we)
        begin
            n_next      = cfg_sat;
            fcount_next = cfg_sat;
            lcount_next = '0;
            faults_next = '0;
        end

        if (ctl.pop)
        begin
            fcount_next = fcount_reg - 1'b1;
            lcount_next = lcount_reg + 1'b1;
        end
        if (ctl.load)
            faults_next = faults_reg + 1'b1;

        if (is_fault)
        begin
            out_valid_next   = 1'b1;
            out_frame_next   = ctl.load ? FRAME_OUT_W'(load_frame) : '0;
            out_evicted_next = ctl.shift;
            out_vpid_next    = ctl.shift ? o_owner[0] : '0;
            out_vpage_next   = ctl.shift ? o_page[0] : '0;
            out_freed_next   = '0;
            out_free_next    = CNT_OUT_W'(fcount_next);
            out_paged_next   = faults_next;
            out_status_next  = ctl.load ? ST_OK : ST_NO_FRAME;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (is_rel)
                begin
                    state_next = S_SCAN;
                    pid_next   = req.pid;
                    scan_next  = '0;
                    freed_next = '0;
                end
            end
            S_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (hit)
                begin
                    fcount_next = fcount_reg + 1'b1;
                    lcount_next = lcount_reg - 1'b1;
                    freed_next  = freed_reg + 1'b1;
                end
                if (scan_reg == LAST_SCAN)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free_slot)
                begin
                    state_next       = S_IDLE;
                    out_valid_next   = 1'b1;
                    out_frame_next   = '0;
                    out_evicted_next = 1'b0;
                    out_vpid_next    = '0;
                    out_vpage_next   = '0;
                    out_freed_next   = CNT_OUT_W'(freed_reg);
                    out_free_next    = CNT_OUT_W'(fcount_reg);
                    out_paged_next   = faults_reg;
                    out_status_next  = ST_OK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= CW'(RESET_N);
            fcount_reg    <= CW'(RESET_N);
            lcount_reg    <= '0;
            faults_reg    <= '0;
            freed_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            fcount_reg    <= fcount_next;
            lcount_reg    <= lcount_next;
            faults_reg    <= faults_next;
            freed_reg     <= freed_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pid_reg         <= pid_next;
        out_frame_reg   <= out_frame_next;
        out_evicted_reg <= out_evicted_next;
        out_vpid_reg    <= out_vpid_next;
        out_vpage_reg   <= out_vpage_next;
        out_freed_reg   <= out_freed_next;
        out_free_reg    <= out_free_next;
        out_paged_reg   <= out_paged_next;
        out_status_reg  <= out_status_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.frame_index    = out_frame_reg;
    assign rsp.evicted        = out_evicted_reg;
    assign rsp.victim_owner   = out_vpid_reg;
    assign rsp.victim_page    = out_vpage_reg;
    assign rsp.freed_count    = out_freed_reg;
    assign rsp.free_count     = out_free_reg;
    assign rsp.paged_in_count = out_paged_reg;
    assign rsp.status         = out_status_reg;

    // every managed frame is either free or loaded, never both
    a_frames_conserved: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (32'(fcount_reg) + 32'(lcount_reg) == 32'(n_reg)))
        else $error("free plus loaded frames differ from frames_in_use");

    a_release_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        is_rel |=> (state_reg == S_SCAN) && (scan_reg == '0))
        else $error("release did not start the frame scan");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && scan_reg == LAST_SCAN) |=> (state_reg == S_DONE))
        else $error("scan did not stop after the last frame");

    a_no_frame_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (is_fault && !ctl.load) |-> (fcount_reg == '0) && (lcount_reg == '0))
        else $error("fault refused while a frame was available");

    a_evict_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift |-> o_valid[0])
        else $error("eviction from an empty load-order head");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top import ffa_pkg::*; ();

    localparam int NFR = 64;

    // fault/release result record, one per request
    typedef struct {
        logic [FRAME_OUT_W-1:0] frame_index;
        logic                   evicted;
        logic [PID_W-1:0]       victim_owner;
        logic [PAGE_W-1:0]      victim_page;
        logic [CNT_OUT_W-1:0]   freed_count;
        logic [CNT_OUT_W-1:0]   free_count;
        logic [PAGED_W-1:0]     paged_in_count;
        logic                   status;
    } alloc_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    ffa_req_if req ();
    ffa_rsp_if rsp ();

    fifo_frame_allocator #(.MAX_FRAMES(NFR)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .req      (req),
        .rsp      (rsp)
    );

    always #4 clk = ~clk;

    // ---------------------------------------------------------------
    // Allocator shadow: free list, load-order queue, owner table
    // ---------------------------------------------------------------
    int unsigned        pool_size;
    logic [PID_W-1:0]   owner_tbl [NFR];
    logic [PAGE_W-1:0]  page_tbl  [NFR];
    bit                 used_tbl  [NFR];
    int unsigned        free_q [$];
    int unsigned        load_q [$];
    logic [PAGED_W-1:0] faults_served;

    alloc_rsp_t expected_rsp_q [$];

    int  n_mismatch;
    bit  rsp_hold;          // long receiver hold-off, set by the pressure test
    int  hold_cycles;

    task automatic reload_pool(input int unsigned n);
        pool_size = (n > NFR) ? NFR : n;
        free_q.delete();
        load_q.delete();
        for (int i = 0; i < NFR; i++)
        begin
            used_tbl[i]  = 0;
            owner_tbl[i] = '0;
            page_tbl[i]  = '0;
        end
        for (int unsigned i = 0; i < pool_size; i++)
            free_q.insert(free_q.size(), i);
        faults_served = '0;
    endtask

    // compute result of one request and advance the shadow state
    function automatic alloc_rsp_t allocate_or_release(input action_t act,
                                                       input logic [PID_W-1:0] pid,
                                                       input logic [PAGE_W-1:0] page);
        alloc_rsp_t  r;
        int unsigned fr;
        r = '{default: '0};
        if (act == ACT_FAULT)
        begin
            if (free_q.size() > 0)
            begin
                fr = free_q[0];
                free_q.delete(0);
            end
            else if (load_q.size() > 0)
            begin
                fr = load_q[0];
                load_q.delete(0);
                r.evicted      = 1'b1;
                r.victim_owner = owner_tbl[fr];
                r.victim_page  = page_tbl[fr];
            end
            else
                r.status = ST_NO_FRAME;
            if (r.status == ST_OK)
            begin
                r.frame_index = fr[FRAME_OUT_W-1:0];
                faults_served = faults_served + 1;
                owner_tbl[fr] = pid;
                page_tbl[fr]  = page;
                used_tbl[fr]  = 1;
                load_q.insert(load_q.size(), fr);
            end
        end
        else
        begin
            for (int unsigned i = 0; i < pool_size; i++)
            begin
                if (used_tbl[i] && owner_tbl[i] == pid)
                begin
                    used_tbl[i] = 0;
                    owner_tbl[i] = '0;
                    page_tbl[i] = '0;
                    free_q.insert(free_q.size(), i);
                    for (int j = load_q.size() - 1; j >= 0; j--)
                        if (load_q[j] == i)
                            load_q.delete(j);
                    r.freed_count = r.freed_count + 1'b1;
                end
            end
        end
        r.free_count     = CNT_OUT_W'(free_q.size());
        r.paged_in_count = faults_served;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Request driver: one transfer, random gap before it
    // ---------------------------------------------------------------
    task automatic send_request(input action_t act, input logic [PID_W-1:0] pid,
                                input logic [PAGE_W-1:0] page, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.action     <= act;
        req.pid        <= pid;
        req.fault_page <= page;
        do @(posedge clk); while (!req.ready);
        expected_rsp_q.insert(expected_rsp_q.size(), allocate_or_release(act, pid, page));
        @(negedge clk);
    endtask

    // wait for all results, then the block's release latency, before a cfg write
    task automatic drain_and_config(input logic [CFG_W-1:0] val);
        req.valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(negedge clk);
        repeat (NFR + 8) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        reload_pool(int'(val));
    endtask

    // ---------------------------------------------------------------
    // Response side: random ready, checker on every transfer
    // ---------------------------------------------------------------
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold)
                rsp.ready <= 1'b0;
            else if (($urandom_range(0, 3) == 0) || ($urandom_range(0, 9) != 0))
                rsp.ready <= 1'b1;
            else
            begin
                stall = $urandom_range(1, 19);
                rsp.ready <= 1'b0;
                repeat (stall) @(negedge clk);
                rsp.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            alloc_rsp_t e;
            if (expected_rsp_q.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result transfer at %0t", $time);
            end
            else
            begin
                e = expected_rsp_q[0];
                expected_rsp_q.delete(0);
                if (rsp.frame_index !== e.frame_index || rsp.evicted !== e.evicted
                    || rsp.victim_owner !== e.victim_owner
                    || rsp.victim_page !== e.victim_page
                    || rsp.freed_count !== e.freed_count || rsp.free_count !== e.free_count
                    || rsp.paged_in_count !== e.paged_in_count || rsp.status !== e.status)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                    begin
                        $display({"mismatch at %0t: exp fr=%0d ev=%0d vo=%0d vpg=%0d",
                                  " fd=%0d fc=%0d pc=%0d st=%0d"},
                                 $time, e.frame_index, e.evicted, e.victim_owner,
                                 e.victim_page, e.freed_count, e.free_count,
                                 e.paged_in_count, e.status);
                        $display("    got fr=%0d ev=%0d vo=%0d vpg=%0d fd=%0d fc=%0d pc=%0d st=%0d",
                                 rsp.frame_index, rsp.evicted, rsp.victim_owner,
                                 rsp.victim_page, rsp.freed_count, rsp.free_count,
                                 rsp.paged_in_count, rsp.status);
                    end
                end
            end
        end
    end

    // long receiver hold-off counted here
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles == 1)
                rsp_hold <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // pids drawn mostly from a small set so releases actually hit frames
    function automatic logic [PID_W-1:0] pick_pid();
        case ($urandom_range(0, 3))
            0: return PID_W'($urandom_range(0, 255));
            1: return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
            default: return PID_W'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic run_mix(input int n, input int release_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < release_pct)
                send_request(ACT_RELEASE, pick_pid(), PAGE_W'($urandom_range(0, 1023)));
            else
                send_request(ACT_FAULT, pick_pid(), PAGE_W'($urandom_range(0, 1023)));
        end
    endtask

    // extremes of fields, release of nothing, default pool size
    task automatic test_directed();
        send_request(ACT_FAULT, 8'h00, 10'h000);
        send_request(ACT_FAULT, 8'hFF, 10'h3FF);
        send_request(ACT_FAULT, 8'hAA, 10'h155);
        send_request(ACT_FAULT, 8'h55, 10'h2AA);
        send_request(ACT_RELEASE, 8'h77, 10'h3FF);   // owns nothing
        send_request(ACT_RELEASE, 8'hFF, 10'h000);
        send_request(ACT_FAULT, 8'h01, 10'h001);
    endtask

    // tiny pool: evictions, releases out of the middle of the load order
    task automatic test_small_pool();
        drain_and_config(7'd2);
        for (int i = 0; i < 6; i++)
            send_request(ACT_FAULT, i[7:0], PAGE_W'(i * 100));
        send_request(ACT_RELEASE, 8'd5, 10'd0);
        send_request(ACT_FAULT, 8'd9, 10'd9);
        drain_and_config(7'd3);
        run_mix(150, 25);
    endtask

    // zero frames: every fault reports no frame
    task automatic test_no_frames();
        drain_and_config(7'd0);
        send_request(ACT_FAULT, 8'd3, 10'd3);
        send_request(ACT_RELEASE, 8'd3, 10'd0);
        send_request(ACT_FAULT, 8'hFF, 10'h3FF);
    endtask

    // write above the maximum saturates to 64 frames
    task automatic test_saturate();
        drain_and_config(7'h7F);
        run_mix(300, 10);
        drain_and_config(7'd64);
        run_mix(200, 15);
    endtask

    task automatic test_random_sizes();
        for (int k = 0; k < 6; k++)
        begin
            drain_and_config(CFG_W'($urandom_range(1, 16)));
            run_mix(140, 20);
        end
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        drain_and_config(7'd8);
        @(negedge clk);
        rsp_hold    <= 1'b1;
        hold_cycles <= 300;
        for (int i = 0; i < 40; i++)
            send_request(ACT_FAULT, pick_pid(), PAGE_W'($urandom_range(0, 1023)), 1);
    endtask

    initial
    begin
        req.valid      = 1'b0;
        req.action     = ACT_FAULT;
        req.pid        = '0;
        req.fault_page = '0;
        n_mismatch     = 0;
        rsp_hold       = 1'b0;
        hold_cycles    = 0;
        reload_pool(FRAMES_RESET);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_small_pool();
        test_no_frames();
        test_saturate();
        test_random_sizes();
        test_backpressure();

        req.valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(negedge clk);
        repeat (NFR + 8) @(negedge clk);
        if (n_mismatch == 0 && expected_rsp_q.size() == 0)
            $display("fifo_frame_allocator test passed");
        else
            $display("fifo_frame_allocator test failed");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("fifo_frame_allocator test failed");
        $finish;
    end

endmodule
